### sv/s16c_pkg.sv
package s16c_pkg;

  typedef enum logic [2:0] {
    OP_WMEM  = 3'd0,
    OP_WREG  = 3'd1,
    OP_START = 3'd2,
    OP_STEP  = 3'd3,
    OP_RMEM  = 3'd4,
    OP_RREG  = 3'd5,
    OP_WSTAT = 3'd6,
    OP_NONE  = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC,
    ST_LOAD,
    ST_PUSH,
    ST_POP_ADDR,
    ST_POP,
    ST_FINISH,
    ST_DONE
  } state_t;

  localparam logic [2:0] CFG_BASE  = 3'd0;
  localparam logic [2:0] CFG_LIMIT = 3'd1;
  localparam logic [2:0] CFG_SLICE = 3'd2;
  localparam logic [2:0] CFG_PC    = 3'd3;
  localparam logic [2:0] CFG_STACK = 3'd4;

  localparam logic [2:0] EX_SLICE = 3'd0;
  localparam logic [2:0] EX_HALT  = 3'd1;
  localparam logic [2:0] EX_BOUND = 3'd2;
  localparam logic [2:0] EX_OVF   = 3'd3;
  localparam logic [2:0] EX_UNF   = 3'd4;
  localparam logic [2:0] EX_OPC   = 3'd5;
  localparam logic [2:0] EX_READ  = 3'd6;
  localparam logic [2:0] EX_WRITE = 3'd7;

  localparam logic [4:0] I_LOAD  = 5'd0;
  localparam logic [4:0] I_STORE = 5'd1;
  localparam logic [4:0] I_ADD   = 5'd2;
  localparam logic [4:0] I_ADDC  = 5'd3;
  localparam logic [4:0] I_SUB   = 5'd4;
  localparam logic [4:0] I_SUBC  = 5'd5;
  localparam logic [4:0] I_AND   = 5'd6;
  localparam logic [4:0] I_XOR   = 5'd7;
  localparam logic [4:0] I_COMPL = 5'd8;
  localparam logic [4:0] I_SHL   = 5'd9;
  localparam logic [4:0] I_SHLA  = 5'd10;
  localparam logic [4:0] I_SHR   = 5'd11;
  localparam logic [4:0] I_SHRA  = 5'd12;
  localparam logic [4:0] I_COMPR = 5'd13;
  localparam logic [4:0] I_GETST = 5'd14;
  localparam logic [4:0] I_PUTST = 5'd15;
  localparam logic [4:0] I_JUMP  = 5'd16;
  localparam logic [4:0] I_JUMPL = 5'd17;
  localparam logic [4:0] I_JUMPE = 5'd18;
  localparam logic [4:0] I_JUMPG = 5'd19;
  localparam logic [4:0] I_CALL  = 5'd20;
  localparam logic [4:0] I_RET   = 5'd21;
  localparam logic [4:0] I_READ  = 5'd22;
  localparam logic [4:0] I_WRITE = 5'd23;
  localparam logic [4:0] I_HALT  = 5'd24;
  localparam logic [4:0] I_NOOP  = 5'd25;

  localparam int FRAME_WORDS = 6;

endpackage

### sv/sixteen_bit_four_register_cpu.sv
// Command-driven 16-bit processor with four registers and a local word memory. A command is
// taken when start is high and busy is low; busy then stays high until done pulses for one
// cycle with the result, which the receiver must take in that cycle, and the next command can
// be taken in the cycle after done. Memory and register writes and reads, start and status
// writes, and a step while stopped or with the program counter outside the region pass
// through the fetch and finish states only. A step that executes also passes through decode
// and execute, with one shared adder, and a load from memory through a load state as well;
// call and return move one stack word per cycle through the memory in push or pop states, or
// go straight to finish when the stack check fails. No clearing pass follows reset.
module sixteen_bit_four_register_cpu #(
  parameter int MEM_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_location,
  input  logic signed [15:0] in_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic signed [15:0] out_read_value,
  output logic [8:0]  out_program_counter,
  output logic [8:0]  out_stack_pointer,
  output logic [9:0]  out_status_word,
  output logic [15:0] out_clock_count,
  output logic        out_stopped,
  output logic [2:0]  out_exit_code,
  output logic [1:0]  out_io_register
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [9:0] MEM_W = 10'(MEM_WORDS);

  s16c_pkg::state_t state_r, state_nxt;

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0] mem_wd;

  logic [7:0]  base_r;
  logic [8:0]  limit_r;
  logic [15:0] slice_r;
  logic [7:0]  spc_r;
  logic [8:0]  stop_r;

  logic [15:0] regs_r [4];
  logic [15:0] regs_nxt [4];
  logic [8:0]  pc_r, pc_nxt;
  logic [8:0]  sp_r, sp_nxt;
  logic [9:0]  st_r, st_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic        halt_r, halt_nxt;
  logic [2:0]  cmd_r;
  logic [7:0]  loc_r;
  logic [15:0] val_r;
  logic [15:0] ir_r, ir_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] rv_r, rv_nxt;

  logic [4:0]  opc;
  logic [1:0]  rd, rs;
  logic        imm;
  logic [9:0]  addr;
  logic [15:0] cons, opa, opb;
  logic [17:0] alu;
  logic [9:0]  reg_end;
  logic        addr_ok, pc_ok;

  always_comb begin
    opc  = ir_r[15:11];
    rd   = ir_r[10:9];
    imm  = ir_r[8];
    rs   = ir_r[7:6];
    addr = 10'(ir_r[7:0]) + 10'(base_r);
    cons = {{8{ir_r[7]}}, ir_r[7:0]};
    opa  = regs_r[rd];
    opb  = imm ? cons : regs_r[rs];
    reg_end = 10'(base_r) + 10'(limit_r);
    addr_ok = (addr < reg_end) && (addr < MEM_W);
    pc_ok   = (10'(pc_r) < reg_end) && (10'(pc_r) < MEM_W);
  end

  // Shared adder: add, subtract, with or without carry.
  logic        sub_sel;
  logic        cin;
  always_comb begin
    sub_sel = (opc == s16c_pkg::I_SUB) || (opc == s16c_pkg::I_SUBC) ||
              (opc == s16c_pkg::I_COMPR);
    cin = ((opc == s16c_pkg::I_ADDC) || (opc == s16c_pkg::I_SUBC)) ? st_r[0] : 1'b0;
    if (sub_sel)
      alu = {{2{opa[15]}}, opa} - {{2{opb[15]}}, opb} - 18'(cin);
    else
      alu = {{2{opa[15]}}, opa} + {{2{opb[15]}}, opb} + 18'(cin);
  end

  function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [2:0] n);
    logic [16:0] s;
    s = 17'(c) + 17'(n);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [9:0] set_ex(input logic [9:0] s, input logic [2:0] e);
    return {s[9:8], e, s[4:0]};
  endfunction

  always_comb begin
    case (state_r)
      s16c_pkg::ST_IDLE:     state_nxt = start ? s16c_pkg::ST_FETCH : s16c_pkg::ST_IDLE;
      s16c_pkg::ST_FETCH: begin
        if (cmd_r == s16c_pkg::OP_STEP && !halt_r && pc_ok)
          state_nxt = s16c_pkg::ST_DECODE;
        else
          state_nxt = s16c_pkg::ST_FINISH;
      end
      s16c_pkg::ST_DECODE:   state_nxt = s16c_pkg::ST_EXEC;
      s16c_pkg::ST_EXEC: begin
        if (opc == s16c_pkg::I_LOAD && !imm && addr_ok)
          state_nxt = s16c_pkg::ST_LOAD;
        else if (opc == s16c_pkg::I_CALL && sp_r >= 9'(limit_r + 9'd6) &&
                 10'(limit_r) + 10'd6 <= 10'(sp_r))
          state_nxt = s16c_pkg::ST_PUSH;
        else if (opc == s16c_pkg::I_RET && 10'(sp_r) + 10'd6 <= MEM_W)
          state_nxt = s16c_pkg::ST_POP_ADDR;
        else
          state_nxt = s16c_pkg::ST_FINISH;
      end
      s16c_pkg::ST_LOAD:     state_nxt = s16c_pkg::ST_FINISH;
      s16c_pkg::ST_PUSH:
        state_nxt = (cnt_r == 3'd5) ? s16c_pkg::ST_FINISH : s16c_pkg::ST_PUSH;
      s16c_pkg::ST_POP_ADDR: state_nxt = s16c_pkg::ST_POP;
      s16c_pkg::ST_POP:
        state_nxt = (cnt_r == 3'd5) ? s16c_pkg::ST_FINISH : s16c_pkg::ST_POP;
      s16c_pkg::ST_FINISH:   state_nxt = s16c_pkg::ST_DONE;
      s16c_pkg::ST_DONE:     state_nxt = s16c_pkg::ST_IDLE;
      default:               state_nxt = s16c_pkg::ST_IDLE;
    endcase
  end

  // Memory port control.
  logic [9:0] push_a, pop_a;
  always_comb begin
    push_a = 10'(sp_r) - 10'd1 - 10'(cnt_r);
    pop_a  = 10'(sp_r) + 10'(cnt_r);
    mem_we = 1'b0;
    mem_wa = loc_r[AW-1:0];
    mem_wd = val_r;
    mem_ra = loc_r[AW-1:0];
    case (state_r)
      s16c_pkg::ST_IDLE: begin
        mem_we = 1'b0;
      end
      s16c_pkg::ST_FETCH: begin
        mem_ra = (cmd_r == s16c_pkg::OP_STEP) ? pc_r[AW-1:0] : loc_r[AW-1:0];
        mem_we = (cmd_r == s16c_pkg::OP_WMEM) && (10'(loc_r) < MEM_W);
      end
      s16c_pkg::ST_EXEC: begin
        mem_ra = addr[AW-1:0];
        mem_wa = addr[AW-1:0];
        mem_wd = opa;
        mem_we = (opc == s16c_pkg::I_STORE) && addr_ok;
      end
      s16c_pkg::ST_PUSH: begin
        mem_wa = push_a[AW-1:0];
        case (cnt_r)
          3'd0:    mem_wd = 16'(pc_r);
          3'd1:    mem_wd = regs_r[3];
          3'd2:    mem_wd = regs_r[2];
          3'd3:    mem_wd = regs_r[1];
          3'd4:    mem_wd = regs_r[0];
          default: mem_wd = 16'(st_r);
        endcase
        mem_we = push_a < MEM_W;
      end
      s16c_pkg::ST_POP_ADDR: mem_ra = sp_r[AW-1:0];
      s16c_pkg::ST_POP:      mem_ra = pop_a[AW-1:0];
      default:               mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) regs_nxt[i] = regs_r[i];
    pc_nxt = pc_r;
    sp_nxt = sp_r;
    st_nxt = st_r;
    cc_nxt = cc_r;
    halt_nxt = halt_r;
    ir_nxt = ir_r;
    cnt_nxt = cnt_r;
    rv_nxt = rv_r;
    case (state_r)
      s16c_pkg::ST_IDLE: begin
        rv_nxt = 16'd0;
        cnt_nxt = 3'd0;
      end
      s16c_pkg::ST_FETCH: begin
        case (cmd_r)
          s16c_pkg::OP_WREG:
            if (loc_r < 8'd4) regs_nxt[loc_r[1:0]] = val_r;
          s16c_pkg::OP_START: begin
            pc_nxt = 9'(spc_r);
            sp_nxt = stop_r;
            cc_nxt = 16'd0;
            halt_nxt = 1'b0;
          end
          s16c_pkg::OP_STEP:
            if (!halt_r) begin
              if (!pc_ok) begin
                st_nxt = set_ex(st_r, s16c_pkg::EX_BOUND);
                halt_nxt = 1'b1;
              end else begin
                pc_nxt = pc_r + 9'd1;
              end
            end
          s16c_pkg::OP_RREG:
            if (loc_r < 8'd4) rv_nxt = regs_r[loc_r[1:0]];
          s16c_pkg::OP_WSTAT: st_nxt = val_r[9:0];
          default: ;
        endcase
      end
      s16c_pkg::ST_DECODE: begin
        ir_nxt = rdata_r;
        cc_nxt = sat_add(cc_r, 3'd1);
      end
      s16c_pkg::ST_EXEC: begin
        case (opc)
          s16c_pkg::I_LOAD: begin
            if (imm) regs_nxt[rd] = cons;
            else if (!addr_ok) begin
              st_nxt = set_ex(st_r, s16c_pkg::EX_BOUND);
              halt_nxt = 1'b1;
            end else cc_nxt = sat_add(cc_r, 3'd3);
          end
          s16c_pkg::I_STORE: begin
            if (!addr_ok) begin
              st_nxt = set_ex(st_r, s16c_pkg::EX_BOUND);
              halt_nxt = 1'b1;
            end else cc_nxt = sat_add(cc_r, 3'd3);
          end
          s16c_pkg::I_ADD, s16c_pkg::I_SUB: begin
            regs_nxt[rd] = alu[15:0];
            if (((opc == s16c_pkg::I_ADD) ? (opa[15] == opb[15]) : (opa[15] != opb[15]))
                && alu[15] != opa[15]) begin
              st_nxt = alu[16] ? {st_r[9:5], 1'b1, st_r[3:1], 1'b1}
                               : {5'd0, 1'b1, st_r[3:1], 1'b0};
              halt_nxt = 1'b1;
            end else st_nxt = {6'd0, st_r[3:1], alu[16]};
          end
          s16c_pkg::I_ADDC, s16c_pkg::I_SUBC: begin
            regs_nxt[rd] = alu[15:0];
            st_nxt = alu[16] ? {st_r[9:1], 1'b1} : {5'd0, st_r[4:1], 1'b0};
          end
          s16c_pkg::I_AND:   regs_nxt[rd] = opa & opb;
          s16c_pkg::I_XOR:   regs_nxt[rd] = opa ^ opb;
          s16c_pkg::I_COMPL: regs_nxt[rd] = ~opa;
          s16c_pkg::I_SHL: begin
            regs_nxt[rd] = {opa[14:0], 1'b0};
            st_nxt = opa[15] ? {st_r[9:1], 1'b1} : {5'd0, st_r[4:1], 1'b0};
          end
          s16c_pkg::I_SHLA: begin
            regs_nxt[rd] = {opa[15], opa[13:0], 1'b0};
            st_nxt = opa[15] ? {st_r[9:1], 1'b1} : {5'd0, st_r[4:1], 1'b0};
          end
          s16c_pkg::I_SHR, s16c_pkg::I_SHRA: begin
            regs_nxt[rd] = {(opc == s16c_pkg::I_SHRA) & opa[15], opa[15:1]};
            st_nxt = opa[0] ? {st_r[9:1], 1'b1} : {5'd0, st_r[4:1], 1'b0};
          end
          s16c_pkg::I_COMPR: begin
            if ($signed(opa) < $signed(opb)) st_nxt = {5'd0, st_r[4], 3'b100, st_r[0]};
            else if (opa != opb) st_nxt = {5'd0, st_r[4], 3'b001, st_r[0]};
            else st_nxt = {5'd0, st_r[4], 3'b010, st_r[0]};
          end
          s16c_pkg::I_GETST: regs_nxt[rd] = 16'(st_r);
          s16c_pkg::I_PUTST: st_nxt = opa[9:0];
          s16c_pkg::I_JUMP, s16c_pkg::I_JUMPL, s16c_pkg::I_JUMPE, s16c_pkg::I_JUMPG: begin
            if (!addr_ok) begin
              st_nxt = set_ex(st_r, s16c_pkg::EX_BOUND);
              halt_nxt = 1'b1;
            end else if (opc == s16c_pkg::I_JUMP || (opc == s16c_pkg::I_JUMPL && st_r[3]) ||
                         (opc == s16c_pkg::I_JUMPE && st_r[2]) ||
                         (opc == s16c_pkg::I_JUMPG && st_r[1]))
              pc_nxt = addr[8:0];
          end
          s16c_pkg::I_CALL:
            if (10'(sp_r) < 10'(limit_r) + 10'd6) begin
              st_nxt = set_ex(st_r, s16c_pkg::EX_OVF);
              halt_nxt = 1'b1;
            end
          s16c_pkg::I_RET:
            if (10'(sp_r) + 10'd6 > MEM_W) begin
              st_nxt = set_ex(st_r, s16c_pkg::EX_UNF);
              halt_nxt = 1'b1;
            end
          s16c_pkg::I_READ, s16c_pkg::I_WRITE: begin
            st_nxt = {rd | st_r[9:8],
                      (opc == s16c_pkg::I_READ) ? s16c_pkg::EX_READ : s16c_pkg::EX_WRITE,
                      st_r[4:0]};
            halt_nxt = 1'b1;
          end
          s16c_pkg::I_HALT: begin
            st_nxt = set_ex(st_r, s16c_pkg::EX_HALT);
            halt_nxt = 1'b1;
          end
          s16c_pkg::I_NOOP: ;
          default: begin
            st_nxt = set_ex(st_r, s16c_pkg::EX_OPC);
            halt_nxt = 1'b1;
          end
        endcase
      end
      s16c_pkg::ST_LOAD: regs_nxt[rd] = rdata_r;
      s16c_pkg::ST_PUSH: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          sp_nxt = sp_r - 9'd6;
          if (!addr_ok) begin
            st_nxt = set_ex(st_r, s16c_pkg::EX_BOUND);
            halt_nxt = 1'b1;
          end else begin
            pc_nxt = addr[8:0];
            cc_nxt = sat_add(cc_r, 3'd3);
          end
        end
      end
      s16c_pkg::ST_POP_ADDR: cnt_nxt = 3'd1;
      s16c_pkg::ST_POP: begin
        cnt_nxt = cnt_r + 3'd1;
        case (cnt_r)
          3'd1:    st_nxt = rdata_r[9:0];
          3'd2:    regs_nxt[0] = rdata_r;
          3'd3:    regs_nxt[1] = rdata_r;
          3'd4:    regs_nxt[2] = rdata_r;
          3'd5:    regs_nxt[3] = rdata_r;
          default: ;
        endcase
      end
      s16c_pkg::ST_FINISH: begin
        if (cmd_r == s16c_pkg::OP_RMEM && 10'(loc_r) < MEM_W) rv_nxt = rdata_r;
        if (cnt_r == 3'd6 && opc == s16c_pkg::I_RET) begin
          pc_nxt = rdata_r[8:0];
          sp_nxt = sp_r + 9'd6;
          cc_nxt = sat_add(cc_r, 3'd3);
        end
      end
      default: ;
    endcase
  end

  // Tracks whether the current step ran an instruction, for the slice check.
  logic ran_r, ran_nxt;
  always_comb begin
    ran_nxt = ran_r;
    if (state_r == s16c_pkg::ST_IDLE) ran_nxt = 1'b0;
    if (state_r == s16c_pkg::ST_DECODE) ran_nxt = 1'b1;
  end

  logic [15:0] cc_fin;
  logic [9:0]  st_fin;
  logic        slice_end;
  always_comb begin
    cc_fin = cc_nxt;
    st_fin = st_nxt;
    slice_end = (state_r == s16c_pkg::ST_FINISH) && ran_r && (cc_nxt >= slice_r);
    if (slice_end) st_fin = set_ex(st_nxt, s16c_pkg::EX_SLICE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= s16c_pkg::ST_IDLE;
      base_r  <= 8'd0;
      limit_r <= 9'd256;
      slice_r <= 16'd15;
      spc_r   <= 8'd0;
      stop_r  <= 9'd256;
      for (int i = 0; i < 4; i++) regs_r[i] <= 16'd0;
      pc_r    <= 9'd0;
      sp_r    <= 9'd256;
      st_r    <= 10'd0;
      cc_r    <= 16'd0;
      halt_r  <= 1'b1;
      cnt_r   <= 3'd0;
      ran_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          s16c_pkg::CFG_BASE:  base_r  <= cfg_data[7:0];
          s16c_pkg::CFG_LIMIT: limit_r <= cfg_data[8:0];
          s16c_pkg::CFG_SLICE: slice_r <= cfg_data;
          s16c_pkg::CFG_PC:    spc_r   <= cfg_data[7:0];
          s16c_pkg::CFG_STACK: stop_r  <= cfg_data[8:0];
          default: ;
        endcase
      end
      for (int i = 0; i < 4; i++) regs_r[i] <= regs_nxt[i];
      pc_r   <= pc_nxt;
      sp_r   <= sp_nxt;
      st_r   <= st_fin;
      cc_r   <= cc_fin;
      halt_r <= halt_nxt | slice_end;
      cnt_r  <= cnt_nxt;
      ran_r  <= ran_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == s16c_pkg::ST_IDLE && start) begin
      cmd_r <= in_operation;
      loc_r <= in_location;
      val_r <= in_value;
    end
    ir_r <= ir_nxt;
    rv_r <= rv_nxt;
  end

  always_comb begin
    busy      = (state_r != s16c_pkg::ST_IDLE);
    cfg_ready = (state_r == s16c_pkg::ST_IDLE);
    done      = (state_r == s16c_pkg::ST_DONE);
    out_read_value      = rv_r;
    out_program_counter = pc_r;
    out_stack_pointer   = sp_r;
    out_status_word     = st_r;
    out_clock_count     = cc_r;
    out_stopped         = halt_r;
    out_exit_code       = st_r[7:5];
    out_io_register     = st_r[9:8];
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == s16c_pkg::ST_IDLE) else $error("done not followed by idle");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy) else $error("config taken while busy");
  a_push_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == s16c_pkg::ST_PUSH |-> cnt_r <= 3'd5) else $error("push overrun");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command not busy");

endmodule

### dv/tb_sixteen_bit_four_register_cpu.sv
`timescale 1ns / 100ps

module tb_sixteen_bit_four_register_cpu;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    bit [15:0] read_value;
    bit [8:0]  pc;
    bit [8:0]  sp;
    bit [9:0]  status;
    bit [15:0] clocks;
    bit        stopped;
    bit [2:0]  exit_code;
    bit [1:0]  io_reg;
  } cpu_word_t;

  class cpu_shadow;
    bit [15:0] mem [256];
    bit [15:0] regs [4];
    int unsigned pc, sp, status, clocks;
    bit halted;
    int unsigned base, limit, slice_len, start_pc, stack_top;
    cpu_word_t expected_words [$];
    int errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = 0; sp = 256; status = 0; clocks = 0; halted = 1;
      base = 0; limit = 256; slice_len = 15; start_pc = 0; stack_top = 256;
      errors = 0;
    endfunction

    function void set_register(bit [2:0] idx, bit [15:0] data);
      case (idx)
        s16c_pkg::CFG_BASE:  base = data & 'hFF;
        s16c_pkg::CFG_LIMIT: limit = data & 'h1FF;
        s16c_pkg::CFG_SLICE: slice_len = data;
        s16c_pkg::CFG_PC:    start_pc = data & 'hFF;
        s16c_pkg::CFG_STACK: stack_top = data & 'h1FF;
        default: ;
      endcase
    endfunction

    function bit in_region(int unsigned a);
      return a < base + limit && a < 256;
    endfunction

    function int unsigned sx16(int unsigned v);
      v &= 'hFFFF;
      return v[15] ? (v | 'hFFFF0000) : v;
    endfunction

    function void set_exit(int unsigned code);
      status = (status & 'h31F) | ((code & 7) << 5);
      halted = 1;
    endfunction

    function void carry_from(int unsigned r);
      if (r[16]) status |= 1;
      else status &= 'h1E;
    endfunction

    function void charge(int unsigned n);
      int unsigned c;
      c = clocks + n;
      clocks = c > 'hFFFF ? 'hFFFF : c;
    endfunction

    function void mem_write(int unsigned a, int unsigned v);
      if (a < 256) mem[a] = v[15:0];
    endfunction

    function int unsigned mem_read(int unsigned a);
      return a < 256 ? mem[a] : 0;
    endfunction

    function void run_instruction();
      int unsigned ir, opc, rd, imm, rs, addr, cons, a, b, r, s1, s2, rsg, i;
      if (!in_region(pc)) begin
        set_exit(s16c_pkg::EX_BOUND);
        return;
      end
      ir = mem[pc];
      pc = (pc + 1) & 'h1FF;
      opc = (ir >> 11) & 'h1F;
      rd = (ir >> 9) & 3;
      imm = (ir >> 8) & 1;
      rs = (ir >> 6) & 3;
      addr = (ir & 'hFF) + base;
      cons = ir[7] ? ((ir & 'hFF) | 'hFFFFFF00) : (ir & 'hFF);
      a = sx16(regs[rd]);
      b = imm ? cons : sx16(regs[rs]);
      charge(1);
      s1 = (a >> 15) & 1;
      s2 = (b >> 15) & 1;
      case (opc)
        s16c_pkg::I_LOAD: begin
          if (imm) regs[rd] = cons[15:0];
          else if (!in_region(addr)) set_exit(s16c_pkg::EX_BOUND);
          else begin
            regs[rd] = mem[addr];
            charge(3);
          end
        end
        s16c_pkg::I_STORE: begin
          if (!in_region(addr)) set_exit(s16c_pkg::EX_BOUND);
          else begin
            mem[addr] = regs[rd];
            charge(3);
          end
        end
        s16c_pkg::I_ADD, s16c_pkg::I_SUB: begin
          r = (opc == s16c_pkg::I_ADD) ? a + b : a - b;
          rsg = (r >> 15) & 1;
          carry_from(r);
          if ((opc == s16c_pkg::I_ADD) ? (s1 == s2 && rsg != s1)
                                       : (s1 != s2 && rsg != s1)) begin
            status |= 'h10;
            halted = 1;
          end else begin
            status &= 'h0F;
          end
          regs[rd] = r[15:0];
        end
        s16c_pkg::I_ADDC, s16c_pkg::I_SUBC: begin
          r = (opc == s16c_pkg::I_ADDC) ? a + b + (status & 1) : a - b - (status & 1);
          carry_from(r);
          regs[rd] = r[15:0];
        end
        s16c_pkg::I_AND: regs[rd] = 16'(a & b);
        s16c_pkg::I_XOR: regs[rd] = 16'(a ^ b);
        s16c_pkg::I_COMPL: regs[rd] = 16'(~a);
        s16c_pkg::I_SHL: begin
          r = a << 1;
          carry_from(r);
          regs[rd] = r[15:0];
        end
        s16c_pkg::I_SHLA: begin
          r = a << 1;
          if (r[16]) begin
            status |= 1;
            r |= 'h8000;
          end else begin
            status &= 'h1E;
            r &= 'h7FFF;
          end
          regs[rd] = r[15:0];
        end
        s16c_pkg::I_SHR, s16c_pkg::I_SHRA: begin
          if (a[0]) status |= 1;
          else status &= 'h1E;
          r = (a & 'hFFFF) >> 1;
          if (opc == s16c_pkg::I_SHRA) r |= (a & 'h8000);
          regs[rd] = r[15:0];
        end
        s16c_pkg::I_COMPR: begin
          status &= 'h11;
          if ((a ^ 'h80000000) < (b ^ 'h80000000)) status |= 8;
          else if (a != b) status |= 2;
          else status |= 4;
        end
        s16c_pkg::I_GETST: regs[rd] = status[15:0];
        s16c_pkg::I_PUTST: status = regs[rd] & 'h3FF;
        s16c_pkg::I_JUMP, s16c_pkg::I_JUMPL, s16c_pkg::I_JUMPE, s16c_pkg::I_JUMPG: begin
          if (!in_region(addr)) set_exit(s16c_pkg::EX_BOUND);
          else if (opc == s16c_pkg::I_JUMP ||
                   (opc == s16c_pkg::I_JUMPL && status[3]) ||
                   (opc == s16c_pkg::I_JUMPE && status[2]) ||
                   (opc == s16c_pkg::I_JUMPG && status[1]))
            pc = addr;
        end
        s16c_pkg::I_CALL: begin
          if (sp < limit + 6) set_exit(s16c_pkg::EX_OVF);
          else begin
            mem_write(sp - 1, pc);
            for (i = 0; i < 4; i++) mem_write(sp - 2 - i, regs[3 - i]);
            mem_write(sp - 6, status);
            sp = (sp - 6) & 'hFFFF;
            if (!in_region(addr)) set_exit(s16c_pkg::EX_BOUND);
            else begin
              pc = addr;
              charge(3);
            end
          end
        end
        s16c_pkg::I_RET: begin
          if (sp + 6 > 256) set_exit(s16c_pkg::EX_UNF);
          else begin
            status = mem_read(sp) & 'h3FF;
            for (i = 0; i < 4; i++) regs[i] = 16'(mem_read(sp + 1 + i));
            pc = mem_read(sp + 5) & 'h1FF;
            sp = sp + 6;
            charge(3);
          end
        end
        s16c_pkg::I_READ, s16c_pkg::I_WRITE: begin
          status |= rd << 8;
          set_exit(opc == s16c_pkg::I_READ ? s16c_pkg::EX_READ : s16c_pkg::EX_WRITE);
        end
        s16c_pkg::I_HALT: set_exit(s16c_pkg::EX_HALT);
        s16c_pkg::I_NOOP: ;
        default: set_exit(s16c_pkg::EX_OPC);
      endcase
      if (clocks >= slice_len) set_exit(s16c_pkg::EX_SLICE);
    endfunction

    function void note_command(s16c_pkg::cmd_t op, bit [7:0] loc, bit [15:0] val);
      cpu_word_t w;
      w.read_value = '0;
      case (op)
        s16c_pkg::OP_WMEM: mem[loc] = val;
        s16c_pkg::OP_WREG: if (loc < 4) regs[loc] = val;
        s16c_pkg::OP_START: begin
          pc = start_pc;
          sp = stack_top;
          clocks = 0;
          halted = 0;
        end
        s16c_pkg::OP_STEP: if (!halted) run_instruction();
        s16c_pkg::OP_RMEM: w.read_value = mem[loc];
        s16c_pkg::OP_RREG: w.read_value = loc < 4 ? regs[loc] : '0;
        s16c_pkg::OP_WSTAT: status = val & 'h3FF;
        default: ;
      endcase
      w.pc = pc[8:0];
      w.sp = sp[8:0];
      w.status = status[9:0];
      w.clocks = clocks[15:0];
      w.stopped = halted;
      w.exit_code = status[7:5];
      w.io_reg = status[9:8];
      expected_words.push_back(w);
    endfunction

    function void check_result(cpu_word_t got);
      cpu_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (got.read_value !== w.read_value) begin
        $error("read_value exp %h got %h", w.read_value, got.read_value); errors++;
      end
      if (got.pc !== w.pc) begin
        $error("program_counter exp %h got %h", w.pc, got.pc); errors++;
      end
      if (got.sp !== w.sp) begin
        $error("stack_pointer exp %h got %h", w.sp, got.sp); errors++;
      end
      if (got.status !== w.status) begin
        $error("status_word exp %h got %h", w.status, got.status); errors++;
      end
      if (got.clocks !== w.clocks) begin
        $error("clock_count exp %h got %h", w.clocks, got.clocks); errors++;
      end
      if (got.stopped !== w.stopped) begin
        $error("stopped exp %h got %h", w.stopped, got.stopped); errors++;
      end
      if (got.exit_code !== w.exit_code) begin
        $error("exit_code exp %h got %h", w.exit_code, got.exit_code); errors++;
      end
      if (got.io_reg !== w.io_reg) begin
        $error("io_register exp %h got %h", w.io_reg, got.io_reg); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [2:0] in_operation = '0;
  logic [7:0] in_location = '0;
  logic signed [15:0] in_value = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic signed [15:0] out_read_value;
  logic [8:0] out_program_counter, out_stack_pointer;
  logic [9:0] out_status_word;
  logic [15:0] out_clock_count;
  logic out_stopped;
  logic [2:0] out_exit_code;
  logic [1:0] out_io_register;

  cpu_shadow shadow = new();
  int idle_pct = 0;
  int cycles = 0;

  sixteen_bit_four_register_cpu u_top (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    cpu_word_t got;
    if (rst_n && done) begin
      got.read_value = out_read_value;
      got.pc = out_program_counter;
      got.sp = out_stack_pointer;
      got.status = out_status_word;
      got.clocks = out_clock_count;
      got.stopped = out_stopped;
      got.exit_code = out_exit_code;
      got.io_reg = out_io_register;
      shadow.check_result(got);
    end
  end

  task automatic send(s16c_pkg::cmd_t op, bit [7:0] loc, bit [15:0] val);
    int gap;
    start <= 1;
    in_operation <= op;
    in_location <= loc;
    in_value <= val;
    do @(posedge clk); while (busy);
    shadow.note_command(op, loc, val);
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (shadow.expected_words.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(bit [2:0] idx, bit [15:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_register(idx, data);
  endtask

  task automatic configure(int b, int lim, int sl, int spc, int stop);
    drain();
    write_cfg(s16c_pkg::CFG_BASE, 16'(b));
    write_cfg(s16c_pkg::CFG_LIMIT, 16'(lim));
    write_cfg(s16c_pkg::CFG_SLICE, 16'(sl));
    write_cfg(s16c_pkg::CFG_PC, 16'(spc));
    write_cfg(s16c_pkg::CFG_STACK, 16'(stop));
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic bit [15:0] rand_instr();
    bit [15:0] w;
    w = 16'($urandom);
    if ($urandom_range(0, 9) == 0) w[15:11] = 5'($urandom_range(26, 31));
    else w[15:11] = 5'($urandom_range(0, 25));
    if ($urandom_range(0, 1)) w[7:0] = 8'($urandom_range(0, 63));
    return w;
  endfunction

  task automatic run_program(ref int count);
    int len, steps;
    len = $urandom_range(4, 16);
    for (int k = 0; k < len; k++) begin
      send(s16c_pkg::OP_WMEM, 8'(shadow.start_pc + k), rand_instr());
      count++;
    end
    if ($urandom_range(0, 1)) begin
      send(s16c_pkg::OP_WREG, 8'($urandom_range(0, 3)), 16'($urandom));
      count++;
    end
    if ($urandom_range(0, 3) == 0) begin
      send(s16c_pkg::OP_WSTAT, 8'($urandom), 16'($urandom));
      count++;
    end
    send(s16c_pkg::OP_START, 8'($urandom), 16'($urandom));
    steps = $urandom_range(3, 25);
    for (int k = 0; k < steps; k++) send(s16c_pkg::OP_STEP, 8'($urandom), 16'($urandom));
    count += steps + 1;
    send(s16c_pkg::OP_RREG, 8'($urandom_range(0, 4)), 16'($urandom));
    send(s16c_pkg::OP_RMEM, 8'($urandom), 16'($urandom));
    count += 2;
    if ($urandom_range(0, 9) == 0) begin
      send(s16c_pkg::cmd_t'($urandom_range(0, 7)), 8'($urandom), 16'($urandom));
      count++;
    end
  endtask

  task automatic run_phase(int b, int lim, int sl, int spc, int stop, int pct, int n);
    int count;
    count = 0;
    configure(b, lim, sl, spc, stop);
    idle_pct = pct;
    while (count < n) run_program(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(s16c_pkg::OP_STEP, 8'h00, 16'h0000);
    send(s16c_pkg::OP_RREG, 8'd0, 16'h0000);
    send(s16c_pkg::OP_NONE, 8'hFF, 16'hFFFF);
    for (int a = 0; a < 256; a++) send(s16c_pkg::OP_WMEM, 8'(a), 16'($urandom));
    send(s16c_pkg::OP_WMEM, 8'd0, {s16c_pkg::I_ADD, 2'd0, 1'b1, 8'h7F});
    send(s16c_pkg::OP_WMEM, 8'd1, {s16c_pkg::I_ADD, 2'd0, 1'b1, 8'h7F});
    send(s16c_pkg::OP_WMEM, 8'd2, {s16c_pkg::I_RET, 11'd0});
    send(s16c_pkg::OP_WREG, 8'd0, 16'h7F00);
    send(s16c_pkg::OP_WREG, 8'd200, 16'h8000);
    send(s16c_pkg::OP_RREG, 8'd200, 16'h0000);
    send(s16c_pkg::OP_WSTAT, 8'h00, 16'hFFFF);
    send(s16c_pkg::OP_START, 8'h00, 16'h0000);
    send(s16c_pkg::OP_STEP, 8'h00, 16'h0000);
    send(s16c_pkg::OP_STEP, 8'h00, 16'h0000);
    send(s16c_pkg::OP_START, 8'h00, 16'h0000);
    send(s16c_pkg::OP_RMEM, 8'hFF, 16'h0000);
    send(s16c_pkg::OP_WSTAT, 8'h00, 16'h0000);

    run_phase(255, 0, 1, 255, 0, 0, 30);
    run_phase(0, 256, 65535, 0, 256, 0, 40);
    run_phase(0, 200, 300, 0, 256, 0, 200);
    run_phase($urandom_range(0, 20), $urandom_range(100, 200), $urandom_range(20, 200),
              $urandom_range(0, 30), 256, 58, 200);
    run_phase($urandom_range(0, 20), $urandom_range(64, 180), $urandom_range(15, 400),
              $urandom_range(0, 30), $urandom_range(200, 256), 25, 200);
    run_phase(0, 120, 1, 10, 130, 58, 80);
    run_phase($urandom_range(0, 40), $urandom_range(60, 200), $urandom_range(30, 500),
              $urandom_range(0, 60), 256, 0, 200);
    run_phase(0, 150, 100, 0, 255, 25, 140);

    drain();
    if (shadow.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
